### hw/rtl/rdlt_pkg.sv
// Shared types, constants and band tables of the resonance dip length tracker.
package rdlt_pkg;

	localparam int DVD_W = 37;
	localparam int DVS_W = 27;

	localparam logic [DVD_W-1:0] K_OPEN  = 37'd43702500000;
	localparam logic [DVD_W-1:0] K_SHORT = 37'd91245000000;

	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_ARM     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] PH_DONE   = 2'd0;
	localparam logic [1:0] PH_FINE   = 2'd1;
	localparam logic [1:0] PH_COARSE = 2'd2;
	localparam logic [1:0] PH_PEAK   = 2'd3;

	localparam logic [7:0] REG_MODE_SHORT   = 8'd0;
	localparam logic [7:0] REG_DIP_MARGIN   = 8'd1;
	localparam logic [7:0] REG_LENGTH_LOWER = 8'd2;
	localparam logic [7:0] REG_LENGTH_UPPER = 8'd3;

	localparam logic [2:0] BAND_RESET  = 3'd4;
	localparam logic [14:0] GAIN_RESET = 15'd16384;
	localparam logic [5:0] OFFSET_WIDE = 6'd40;

	typedef enum logic [1:0] {
		DS_OPEN_NOW,
		DS_K_NOW,
		DS_K_COARSE,
		DS_MEAN
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P3,
		ST_P3W,
		ST_P3B,
		ST_P2,
		ST_P2W,
		ST_P2B,
		ST_BANDW,
		ST_P1,
		ST_P1W,
		ST_MEAN,
		ST_MEANW,
		ST_FIN,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     accept;
		logic     div_start;
		div_sel_t div_sel;
		logic     peak_upd;
		logic     peak_turn;
		logic     coarse_upd;
		logic     coarse_turn;
		logic     band_upd;
		logic     fine_upd;
		logic     mean_upd;
		logic     fin;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic in_sample;
		logic c_p3hi;
		logic c_p3turn;
		logic c_p2lo;
		logic c_p2turn;
		logic c_p1lo;
		logic c_fin;
		logic div_done;
		logic len_valid;
		logic out_free;
	} dp_stat_t;

	function automatic logic [16:0] step_of(input logic [2:0] code);
		case (code)
			3'd0:    step_of = 17'd1000;
			3'd1:    step_of = 17'd5000;
			3'd2:    step_of = 17'd10000;
			3'd3:    step_of = 17'd50000;
			default: step_of = 17'd100000;
		endcase
	endfunction

	function automatic logic [22:0] step50_of(input logic [2:0] code);
		case (code)
			3'd0:    step50_of = 23'd50000;
			3'd1:    step50_of = 23'd250000;
			3'd2:    step50_of = 23'd500000;
			3'd3:    step50_of = 23'd2500000;
			default: step50_of = 23'd5000000;
		endcase
	endfunction

	function automatic logic [14:0] gain_of(input logic short_mode, input logic [2:0] code);
		case (code)
			3'd0:    gain_of = 15'd16869;
			3'd1:    gain_of = short_mode ? 15'd15773 : 15'd16637;
			3'd2:    gain_of = 15'd17042;
			3'd3:    gain_of = short_mode ? 15'd13828 : 15'd15773;
			default: gain_of = 15'd13500;
		endcase
	endfunction

	// Band from a length; ovf means the length is above 65535.
	function automatic logic [2:0] band_of(input logic ovf, input logic [15:0] len);
		if (ovf || len > 16'd40000) band_of = 3'd0;
		else if (len >= 16'd15000) band_of = 3'd1;
		else if (len >= 16'd8000) band_of = 3'd2;
		else if (len >= 16'd2800) band_of = 3'd3;
		else band_of = 3'd4;
	endfunction

endpackage

### hw/rtl/rdlt_div.sv
// Restoring serial divider, one quotient bit per cycle.
module rdlt_div
	import rdlt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

### hw/rtl/rdlt_dp.sv
// Datapath: registers, search state, length window and output register.
module rdlt_dp
	import rdlt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	output dp_stat_t      stat,
	input  logic          cfg_valid,
	input  logic [7:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic [71:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic [103:0]  m_tdata
);

	localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = 16 + FILL_W;

	logic        mode_short_q;
	logic [9:0]  dip_margin_q;
	logic [15:0] length_lower_q, length_upper_q;

	logic [15:0] adc_q;
	logic [26:0] now_q, prog_q;

	logic [1:0]  phase_q;
	logic [15:0] low_q, high_q;
	logic [26:0] coarse_q;
	logic        found_q;
	logic [2:0]  band_q;
	logic [14:0] gain_q;
	logic [5:0]  offset_q;
	logic [15:0] last_len_q;
	logic [15:0] mean_q;

	logic [15:0]       win_mem [WINDOW_DEPTH];
	logic [15:0]       win_rd_q;
	logic [POS_W-1:0]  pos_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;

	logic             m_tvalid_q;
	logic [103:0]     m_tdata_q;

	logic [DVD_W-1:0] div_dvd, quot;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] k_sel;
	logic             q_ovf;
	logic [15:0]      q16, q_sat;
	logic             len_valid;
	logic             push;
	logic [16:0]      adc_plus_margin, low_plus_margin;
	logic [22:0]      step50;
	logic [27:0]      fine_start, fine_end;

	assign k_sel = mode_short_q ? K_SHORT : K_OPEN;

	always_comb begin
		case (cmd.div_sel)
			DS_OPEN_NOW: begin
				div_dvd = K_OPEN;
				div_dvs = now_q;
			end
			DS_K_NOW: begin
				div_dvd = k_sel;
				div_dvs = now_q;
			end
			DS_K_COARSE: begin
				div_dvd = k_sel;
				div_dvs = coarse_q;
			end
			default: begin
				div_dvd = DVD_W'(sum_q);
				div_dvs = DVS_W'(fill_q);
			end
		endcase
	end

	rdlt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (quot)
	);

	assign q_ovf     = |quot[DVD_W-1:16];
	assign q16       = quot[15:0];
	assign q_sat     = q_ovf ? 16'hFFFF : q16;
	assign len_valid = !q_ovf && (q16 >= length_lower_q) && (q16 <= length_upper_q);
	assign push      = cmd.fine_upd && len_valid;

	assign adc_plus_margin = {1'b0, adc_q} + {7'b0, dip_margin_q};
	assign low_plus_margin = {1'b0, low_q} + {7'b0, dip_margin_q};
	assign step50          = step50_of(band_q);
	assign fine_start      = {1'b0, coarse_q} - {5'b0, step50};
	assign fine_end        = {1'b0, coarse_q} + {5'b0, step50};

	always_comb begin
		stat.in_sample = (s_tuser == OP_SAMPLE);
		stat.c_p3hi    = mode_short_q && phase_q == PH_PEAK && high_q < adc_q;
		stat.c_p3turn  = mode_short_q && phase_q == PH_PEAK && {1'b0, high_q} > adc_plus_margin;
		stat.c_p2lo    = phase_q == PH_COARSE && low_q > adc_q;
		stat.c_p2turn  = phase_q == PH_COARSE && low_plus_margin <= {1'b0, adc_q};
		stat.c_p1lo    = phase_q == PH_FINE && low_q > adc_q;
		stat.c_fin     = phase_q == PH_FINE && !found_q && {1'b0, prog_q} >= fine_end;
		stat.div_done  = div_done;
		stat.len_valid = len_valid;
		stat.out_free  = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			adc_q  <= s_tdata[15:0];
			now_q  <= s_tdata[42:16];
			prog_q <= s_tdata[69:43];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_short_q   <= 1'b0;
			dip_margin_q   <= 10'd20;
			length_lower_q <= 16'd500;
			length_upper_q <= 16'd60000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE_SHORT:   mode_short_q   <= cfg_data[0];
				REG_DIP_MARGIN:   dip_margin_q   <= cfg_data[9:0];
				REG_LENGTH_LOWER: length_lower_q <= cfg_data;
				REG_LENGTH_UPPER: length_upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DONE;
			low_q      <= 16'hFFFF;
			high_q     <= '0;
			coarse_q   <= '0;
			found_q    <= 1'b0;
			band_q     <= BAND_RESET;
			gain_q     <= GAIN_RESET;
			offset_q   <= '0;
			last_len_q <= '0;
			mean_q     <= '0;
			pos_q      <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
		end else begin
			if (cmd.accept && s_tuser == OP_ARM) begin
				phase_q <= mode_short_q ? PH_PEAK : PH_COARSE;
				low_q   <= 16'hFFFF;
				high_q  <= '0;
			end
			if (cmd.accept && s_tuser == OP_RESTART) found_q <= 1'b0;
			if (cmd.peak_upd) begin
				coarse_q   <= now_q;
				last_len_q <= q_sat;
				if (len_valid) high_q <= adc_q;
			end
			if (cmd.peak_turn) phase_q <= PH_COARSE;
			if (cmd.coarse_upd) begin
				coarse_q   <= now_q;
				last_len_q <= q_sat;
				if (len_valid) low_q <= adc_q;
			end
			if (cmd.coarse_turn) begin
				phase_q <= PH_FINE;
				low_q   <= 16'hFFFF;
				found_q <= 1'b1;
			end
			if (cmd.band_upd) begin
				last_len_q <= q_sat;
				band_q     <= band_of(q_ovf, q16);
				gain_q     <= gain_of(mode_short_q, band_of(q_ovf, q16));
				offset_q   <= (band_of(q_ovf, q16) == BAND_RESET) ? OFFSET_WIDE : 6'd0;
			end
			if (cmd.fine_upd) last_len_q <= q_sat;
			if (push) begin
				low_q <= adc_q;
				if (fill_q >= FILL_W'(WINDOW_DEPTH)) begin
					sum_q <= sum_q - SUM_W'(win_rd_q) + SUM_W'(q16);
				end else begin
					sum_q  <= sum_q + SUM_W'(q16);
					fill_q <= fill_q + 1'b1;
				end
				pos_q <= (pos_q == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
			end
			if (cmd.mean_upd) mean_q <= quot[15:0];
			if (cmd.fin) phase_q <= PH_DONE;
		end
	end

	// Window store: written on a push, read at the current slot every cycle.
	always_ff @(posedge clk) begin
		if (push) win_mem[pos_q] <= q16;
		win_rd_q <= win_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= {3'b0, mean_q, last_len_q, fine_start, offset_q, gain_q,
				step_of(band_q), found_q, phase_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hw/rtl/rdlt_ctrl.sv
// Controller: sequences the search steps and the divider for one request.
module rdlt_ctrl
	import rdlt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = stat.in_sample ? ST_P3 : ST_OUT;
			ST_P3:    state_d = stat.c_p3hi ? ST_P3W : ST_P3B;
			ST_P3W:   if (stat.div_done) state_d = ST_P3B;
			ST_P3B:   state_d = ST_P2;
			ST_P2:    state_d = stat.c_p2lo ? ST_P2W : ST_P2B;
			ST_P2W:   if (stat.div_done) state_d = ST_P2B;
			ST_P2B:   state_d = stat.c_p2turn ? ST_BANDW : ST_P1;
			ST_BANDW: if (stat.div_done) state_d = ST_P1;
			ST_P1:    state_d = stat.c_p1lo ? ST_P1W : ST_FIN;
			ST_P1W:   if (stat.div_done) state_d = stat.len_valid ? ST_MEAN : ST_FIN;
			ST_MEAN:  state_d = ST_MEANW;
			ST_MEANW: if (stat.div_done) state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DS_K_NOW;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.accept = s_tvalid;
			ST_P3: begin
				cmd.div_start = stat.c_p3hi;
				cmd.div_sel   = DS_OPEN_NOW;
			end
			ST_P3W:  cmd.peak_upd = stat.div_done;
			ST_P3B:  cmd.peak_turn = stat.c_p3turn;
			ST_P2:   cmd.div_start = stat.c_p2lo;
			ST_P2W:  cmd.coarse_upd = stat.div_done;
			ST_P2B: begin
				cmd.coarse_turn = stat.c_p2turn;
				cmd.div_start   = stat.c_p2turn;
				cmd.div_sel     = DS_K_COARSE;
			end
			ST_BANDW: cmd.band_upd = stat.div_done;
			ST_P1:    cmd.div_start = stat.c_p1lo;
			ST_P1W:   cmd.fine_upd = stat.div_done;
			ST_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_MEAN;
			end
			ST_MEANW: cmd.mean_upd = stat.div_done;
			ST_FIN:   cmd.fin = stat.c_fin;
			ST_OUT:   cmd.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

### hw/rtl/resonance_dip_length_tracker.sv
// Top level of the resonance dip length tracker.
// An arm, restart or no-op request goes straight to the output register; a sample also
// runs the search steps and waits on the serial divider for each of up to
// five divisions: peak length, dip length, band length, fine length and window mean.
// Throughput: one request at a time; a new request is taken once the previous result is loaded.
// Reset (arst_n low, asynchronous) clears phase, levels, band, window counters and the configuration registers.
module resonance_dip_length_tracker
	import rdlt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: adc_level[15:0], sweep_now_hz[42:16], sweep_prog_hz[69:43], zero fill.
	input  logic [71:0]  s_tdata,
	// s_tuser: op[1:0].
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: phase[1:0], resonance_found[2], step_hz[19:3], gain_q14[34:20],
	// gain_offset[40:35], fine_start_hz[68:41], last_length[84:69],
	// average_length[100:85], zero fill.
	output logic [103:0] m_tdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration writes are to be issued by the user only while the block is idle;
	// the block does not enforce this, and every write is taken.
	assign cfg_ready = 1'b1;

	// The controller walks the peak, dip and fine steps of one sample in
	// order and starts the shared divider whenever a length or the mean is needed.
	rdlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the search state, the length window and the result
	// register, which lets a finished result wait while the next request is taken.
	rdlt_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
